>>> rtl/lsh_pkg.sv
// Shared types and constants of the 3x3 Laplacian sharpening block.
// No dependencies; every other file of the block but lsh_stream_if uses this package.
package lsh_pkg;

    localparam int NUM_CH          = 3;
    localparam int IMG_WIDTH_BITS  = 12;
    localparam int IMG_HEIGHT_BITS = 13;
    localparam int CFG_INDEX_BITS  = 1;
    localparam int CFG_DATA_BITS   = 13;
    // The input row runs two past the last image row during the frame tail,
    // so it needs one bit more than the largest height the register holds.
    localparam int ROW_BITS        = 14;
    localparam int OUT_ROW_BITS    = 13;

    localparam int QUEUE_DEPTH     = 4;
    localparam int QPTR_BITS       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS       = $clog2(QUEUE_DEPTH + 1);

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_WIDTH  = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_HEIGHT = CFG_INDEX_BITS'(1);

    // Lane 0 is blue, lane 1 green, lane 2 red.
    typedef logic [NUM_CH-1:0][7:0] rgb_t;

    typedef struct packed {
        logic       cmd;
        logic [7:0] pixel_blue;
        logic [7:0] pixel_green;
        logic [7:0] pixel_red;
    } in_item_t;

    typedef struct packed {
        logic [7:0] sharp_blue;
        logic [7:0] sharp_green;
        logic [7:0] sharp_red;
        logic [7:0] edge_blue;
        logic [7:0] edge_green;
        logic [7:0] edge_red;
        logic       frame_end;
    } out_item_t;

    // One classified slot: a masked window column plus what to do with it.
    typedef struct packed {
        rgb_t top;
        rgb_t mid;
        rgb_t bot;
        logic col0;
        logic emit;
        logic frame_end;
    } slot_t;

    typedef struct packed {
        logic [QCNT_BITS-1:0] count;
        logic                 empty;
    } q_status_t;

endpackage

>>> rtl/lsh_stream_if.sv
// Valid/ready stream interface used by the pixel and result channels.
// The payload type is set per instance; no other dependencies.
interface lsh_stream_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> rtl/lsh_front.sv
// Front end: configuration registers, raster counters, slot classification
// and the line store. Depends on lsh_pkg and lsh_stream_if.
module lsh_front #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [lsh_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [lsh_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    lsh_stream_if.sink                          pixels,
    input  lsh_pkg::q_status_t                  q_status,
    output logic                                push_valid,
    output lsh_pkg::slot_t                      push_data
);
    import lsh_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int EW = (WW > IMG_WIDTH_BITS) ? WW : IMG_WIDTH_BITS;
    localparam int PW = $clog2(MAX_WIDTH + 2);
    localparam int PB = $bits(rgb_t);
    localparam int EB = 2 * PB;

    localparam logic [IMG_WIDTH_BITS-1:0]  WIDTH_AT_RESET   = IMG_WIDTH_BITS'(640);
    localparam logic [IMG_HEIGHT_BITS-1:0] HEIGHT_AT_RESET  = IMG_HEIGHT_BITS'(480);

    logic [IMG_WIDTH_BITS-1:0]  width_reg;
    logic [IMG_HEIGHT_BITS-1:0] height_reg;
    logic [CW-1:0]              in_col_reg;
    logic [ROW_BITS-1:0]        in_row_reg;
    logic [CW-1:0]              out_col_reg;
    logic [OUT_ROW_BITS-1:0]    out_row_reg;
    logic [PW-1:0]              pend_reg;

    logic                       s1_valid_reg;
    logic [CW-1:0]              s1_col_reg;
    rgb_t                       s1_bot_reg;
    logic                       s1_top_ok_reg;
    logic                       s1_mid_ok_reg;
    logic                       s1_col0_reg;
    logic                       s1_emit_reg;
    logic                       s1_end_reg;
    logic [EB-1:0]              rd_reg;
    logic                       fwd_reg;
    logic [EB-1:0]              fwd_data_reg;

    // Entry layout: upper row in the high half, middle row in the low half.
    logic [EB-1:0]              line_mem [MAX_WIDTH];

    logic [EW-1:0]              w_cfg;
    logic [EW-1:0]              w_max;
    logic [WW-1:0]              w_eff;
    logic [IMG_HEIGHT_BITS-1:0] h_eff;
    logic [ROW_BITS-1:0]        h_row;
    logic                       take;
    logic                       is_drain;
    logic                       restart;
    logic [CW-1:0]              col;
    logic [ROW_BITS-1:0]        row;
    logic [PW-1:0]              pend;
    logic [CW-1:0]              ocol;
    logic [OUT_ROW_BITS-1:0]    orow;
    rgb_t                       pix;
    rgb_t                       bot;
    logic                       top_ok;
    logic                       mid_ok;
    logic [WW-1:0]              col_inc;
    logic                       col_wrap;
    logic [WW-1:0]              ocol_inc;
    logic                       ocol_wrap;
    logic                       emit;
    logic                       fend;
    logic [CW-1:0]              in_col_next;
    logic [ROW_BITS-1:0]        in_row_next;
    logic [PW-1:0]              pend_next;
    logic [CW-1:0]              out_col_next;
    logic [OUT_ROW_BITS-1:0]    out_row_next;
    logic [EB-1:0]              s1_entry;
    logic [EB-1:0]              wr_entry;

    always_comb
    begin
        w_cfg = EW'(width_reg);
        w_max = EW'(MAX_WIDTH);
        if (width_reg == '0)
        begin
            w_eff = WW'(1);
        end
        else if (w_cfg > w_max)
        begin
            w_eff = WW'(MAX_WIDTH);
        end
        else
        begin
            w_eff = WW'(w_cfg);
        end
        h_eff = (height_reg == '0) ? IMG_HEIGHT_BITS'(1) : height_reg;
        h_row = ROW_BITS'(h_eff);
    end

    always_comb
    begin
        is_drain = pixels.data.cmd == CMD_DRAIN;
        // A drain during pixel slots does nothing; a pixel during the tail
        // abandons the tail and opens a new frame.
        take     = pixels.valid && pixels.ready && !(is_drain && !(in_row_reg >= h_row));
        restart  = !is_drain && (in_row_reg >= h_row);

        col  = restart ? '0 : in_col_reg;
        row  = restart ? '0 : in_row_reg;
        pend = restart ? '0 : pend_reg;
        ocol = restart ? '0 : out_col_reg;
        orow = restart ? '0 : out_row_reg;

        pix    = {pixels.data.pixel_red, pixels.data.pixel_green, pixels.data.pixel_blue};
        bot    = (row < h_row) ? pix : '0;
        mid_ok = (row != '0) && (row <= h_row);
        top_ok = (row >= ROW_BITS'(2)) && ((row - ROW_BITS'(2)) < h_row);

        col_inc     = WW'(col) + WW'(1);
        col_wrap    = col_inc >= w_eff;
        in_col_next = col_wrap ? '0 : CW'(col_inc);
        in_row_next = col_wrap ? row + ROW_BITS'(1) : row;

        // The pending count saturates at width+1; from then on every slot emits.
        emit      = pend == (PW'(w_eff) + PW'(1));
        pend_next = emit ? pend : pend + PW'(1);
        fend      = emit && (orow == (h_eff - IMG_HEIGHT_BITS'(1)))
                         && (WW'(ocol) == (w_eff - WW'(1)));

        ocol_inc     = WW'(ocol) + WW'(1);
        ocol_wrap    = ocol_inc >= w_eff;
        out_col_next = ocol;
        out_row_next = orow;
        if (emit)
        begin
            out_col_next = ocol_wrap ? '0 : CW'(ocol_inc);
            out_row_next = ocol_wrap ? orow + OUT_ROW_BITS'(1) : orow;
        end
    end

    assign pixels.ready = ({1'b0, q_status.count} + {{QCNT_BITS{1'b0}}, s1_valid_reg})
                          < (QCNT_BITS + 1)'(QUEUE_DEPTH);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    <= WIDTH_AT_RESET;
            height_reg   <= HEIGHT_AT_RESET;
            in_col_reg   <= '0;
            in_row_reg   <= '0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            pend_reg     <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= take;
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_IMAGE_WIDTH:  width_reg  <= cfg_data[IMG_WIDTH_BITS-1:0];
                    REG_IMAGE_HEIGHT: height_reg <= cfg_data[IMG_HEIGHT_BITS-1:0];
                    default: ;
                endcase
                in_col_reg  <= '0;
                in_row_reg  <= '0;
                out_col_reg <= '0;
                out_row_reg <= '0;
                pend_reg    <= '0;
            end
            else if (take)
            begin
                if (fend)
                begin
                    in_col_reg  <= '0;
                    in_row_reg  <= '0;
                    out_col_reg <= '0;
                    out_row_reg <= '0;
                    pend_reg    <= '0;
                end
                else
                begin
                    in_col_reg  <= in_col_next;
                    in_row_reg  <= in_row_next;
                    out_col_reg <= out_col_next;
                    out_row_reg <= out_row_next;
                    pend_reg    <= pend_next;
                end
            end
        end
    end

    // The write for a slot lands in the cycle after its read. When the next slot
    // reads the same column in that cycle, the new entry is forwarded.
    assign s1_entry = fwd_reg ? fwd_data_reg : rd_reg;
    assign wr_entry = {s1_entry[PB-1:0], s1_bot_reg};

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            rd_reg        <= line_mem[col];
            fwd_reg       <= s1_valid_reg && (s1_col_reg == col);
            fwd_data_reg  <= wr_entry;
            s1_col_reg    <= col;
            s1_bot_reg    <= bot;
            s1_top_ok_reg <= top_ok;
            s1_mid_ok_reg <= mid_ok;
            s1_col0_reg   <= col == '0;
            s1_emit_reg   <= emit;
            s1_end_reg    <= fend;
        end
        if (s1_valid_reg)
        begin
            line_mem[s1_col_reg] <= wr_entry;
        end
    end

    assign push_valid          = s1_valid_reg;
    assign push_data.top       = s1_top_ok_reg ? s1_entry[EB-1:PB] : '0;
    assign push_data.mid       = s1_mid_ok_reg ? s1_entry[PB-1:0] : '0;
    assign push_data.bot       = s1_bot_reg;
    assign push_data.col0      = s1_col0_reg;
    assign push_data.emit      = s1_emit_reg;
    assign push_data.frame_end = s1_end_reg;

endmodule

>>> rtl/lsh_queue.sv
// Short slot queue that decouples the front end from the filter pipeline.
// Depends on lsh_pkg for the slot type and the depth.
module lsh_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  lsh_pkg::slot_t     push_data,
    input  logic               pop,
    output lsh_pkg::slot_t     pop_data,
    output lsh_pkg::q_status_t status
);
    import lsh_pkg::*;

    slot_t                entries [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg;
    logic [QPTR_BITS-1:0] rd_ptr_reg;
    logic [QCNT_BITS-1:0] count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_BITS'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_BITS'(1);
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + QCNT_BITS'(1);
                2'b01:   count_reg <= count_reg - QCNT_BITS'(1);
                default: count_reg <= count_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data     = entries[rd_ptr_reg];
    assign status.count = count_reg;
    assign status.empty = count_reg == '0;

endmodule

>>> rtl/lsh_back.sv
// Back end: 3x3 window, per-channel Laplacian, clamp, sharpen and the output
// register. Depends on lsh_pkg and lsh_stream_if.
module lsh_back (
    input  logic               clk,
    input  logic               rst_n,
    input  lsh_pkg::q_status_t q_status,
    input  lsh_pkg::slot_t     q_data,
    output logic               pop,
    lsh_stream_if.source       results
);
    import lsh_pkg::*;

    rgb_t [2:0][2:0]          win_reg;
    rgb_t [2:0][2:0]          f_reg;
    logic                     f_valid_reg;
    logic                     f_end_reg;
    logic [NUM_CH-1:0][11:0]  lap_reg;
    rgb_t                     centre_reg;
    logic                     lap_valid_reg;
    logic                     lap_end_reg;
    logic                     out_valid_reg;
    out_item_t                out_data_reg;

    logic                     adv;
    rgb_t [2:0]               new_col;
    rgb_t [2:0][2:0]          fwin;
    rgb_t [2:0][2:0]          win_next;
    logic [NUM_CH-1:0][11:0]  lap;
    rgb_t                     edge_val;
    rgb_t                     sharp_val;

    // The whole pipeline moves when the output register is free or taken.
    assign adv = !out_valid_reg || results.ready;
    assign pop = adv && !q_status.empty;

    always_comb
    begin
        new_col[0] = q_data.top;
        new_col[1] = q_data.mid;
        new_col[2] = q_data.bot;
        for (int r = 0; r < 3; r++)
        begin
            fwin[r][0] = win_reg[r][1];
            fwin[r][1] = win_reg[r][2];
            // The first column of a row closes the previous row, whose
            // right-hand neighbours lie outside the image.
            fwin[r][2] = q_data.col0 ? '0 : new_col[r];
            win_next[r][0] = q_data.col0 ? '0 : fwin[r][0];
            win_next[r][1] = q_data.col0 ? '0 : fwin[r][1];
            win_next[r][2] = new_col[r];
        end
    end

    always_comb
    begin
        logic [10:0] nsum;
        logic [10:0] centre8;
        for (int ch = 0; ch < NUM_CH; ch++)
        begin
            nsum = '0;
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    if (r != 1 || c != 1)
                    begin
                        nsum = nsum + {3'b000, f_reg[r][c][ch]};
                    end
                end
            end
            centre8 = {f_reg[1][1][ch], 3'b000};
            lap[ch] = {1'b0, centre8} - {1'b0, nsum};
        end
    end

    always_comb
    begin
        logic [8:0] sum9;
        for (int ch = 0; ch < NUM_CH; ch++)
        begin
            if (lap_reg[ch][11])
            begin
                edge_val[ch] = '0;
            end
            else if (lap_reg[ch][10:8] != 3'b000)
            begin
                edge_val[ch] = 8'hFF;
            end
            else
            begin
                edge_val[ch] = lap_reg[ch][7:0];
            end
            sum9          = {1'b0, centre_reg[ch]} + {1'b0, edge_val[ch]};
            sharp_val[ch] = sum9[8] ? 8'hFF : sum9[7:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg       <= '0;
            f_valid_reg   <= 1'b0;
            lap_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                win_reg <= win_next;
            end
            if (adv)
            begin
                f_valid_reg   <= pop && q_data.emit;
                lap_valid_reg <= f_valid_reg;
                out_valid_reg <= lap_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f_reg                    <= fwin;
            f_end_reg                <= q_data.frame_end;
            lap_reg                  <= lap;
            centre_reg               <= f_reg[1][1];
            lap_end_reg              <= f_end_reg;
            out_data_reg.sharp_blue  <= sharp_val[0];
            out_data_reg.sharp_green <= sharp_val[1];
            out_data_reg.sharp_red   <= sharp_val[2];
            out_data_reg.edge_blue   <= edge_val[0];
            out_data_reg.edge_green  <= edge_val[1];
            out_data_reg.edge_red    <= edge_val[2];
            out_data_reg.frame_end   <= lap_end_reg;
        end
    end

    assign results.valid = out_valid_reg;
    assign results.data  = out_data_reg;

endmodule

>>> rtl/laplacian_sharpen_3x3_rgb_top.sv
// Top level of the 3x3 Laplacian sharpening block for RGB pixel streams.
// Depends on lsh_pkg, lsh_stream_if, lsh_front, lsh_queue and lsh_back.
//
// Usage: pixels arrive in raster order on the pixels channel (cmd = pixel);
// results leave on the results channel, one per pixel, as the clamped
// 8-neighbour Laplacian (edge_*) and the pixel plus that value saturated at
// 255 (sharp_*). Neighbours outside the image count as zero. A result
// belongs to the pixel accepted image_width+1 slots earlier, so after the
// last pixel of a frame the source sends image_width+1 drain transactions
// (cmd = drain) to flush the tail; frame_end marks the frame's last result.
// image_width and image_height are written through the cfg port while the
// block is idle; a write restarts the frame.
// Throughput: one transaction per cycle while the queue has room, set by the
// line store, which is read and written back once per slot with forwarding
// between neighbours. A releasing transaction passes the slot register, queue,
// window, Laplacian and output registers. Reset: 640 x 480, all positions
// zero; the line store is not cleared, its stale rows are masked by row
// position, so no clearing pass is needed. Stall: the output register holds
// its result and the filter pipeline freezes; a four-entry queue absorbs
// slots until the pixels channel drops ready.
module laplacian_sharpen_3x3_rgb_top #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic [lsh_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [lsh_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    lsh_stream_if.sink                         pixels,
    lsh_stream_if.source                       results
);
    import lsh_pkg::*;

    logic      push_valid;
    slot_t     push_data;
    logic      pop;
    slot_t     q_data;
    q_status_t q_status;

    lsh_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .pixels     (pixels),
        .q_status   (q_status),
        .push_valid (push_valid),
        .push_data  (push_data)
    );

    lsh_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push_valid),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (q_data),
        .status    (q_status)
    );

    lsh_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_status (q_status),
        .q_data   (q_data),
        .pop      (pop),
        .results  (results)
    );

endmodule

>>> rtl/lsh_checker.sv
// Port-level checks of the sharpening block, attached to the top level by
// the bind statement at the end. Depends on lsh_pkg.
module lsh_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input lsh_pkg::out_item_t out_data
);

    // A stalled result keeps its value until the transaction completes.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // Sharpened value is the pixel plus the edge value, so never below it.
    a_sharp_ge_edge: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.sharp_blue >= out_data.edge_blue)
                   && (out_data.sharp_green >= out_data.edge_green)
                   && (out_data.sharp_red >= out_data.edge_red))
        else $error("sharpened value below edge value");

    // Right after reset, before any slot can pass the pipeline, no result is shown.
    a_quiet_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !out_valid ##1 !out_valid ##1 !out_valid ##1 !out_valid)
        else $error("result shown too soon after reset");

    // The queue is empty after reset, so pixels are taken at once.
    a_ready_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> in_ready)
        else $error("pixels channel not ready after reset");

endmodule

bind laplacian_sharpen_3x3_rgb_top lsh_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (pixels.ready),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .out_data  (results.data)
);

>>> tb/lsh_tb_pkg.sv
// Frame geometry helpers for the sharpening testbench.
// Depends on lsh_pkg for the register widths.
package lsh_tb_pkg;

    localparam int LINE_MAX = 2048;

    // Pixels per row as the block uses them: zero means one, and the
    // line store caps the row length.
    function automatic int unsigned line_width(logic [lsh_pkg::IMG_WIDTH_BITS-1:0] value);
        if (value == 0)
        begin
            return 1;
        end
        if (value > LINE_MAX)
        begin
            return LINE_MAX;
        end
        return value;
    endfunction

    function automatic int unsigned frame_rows(logic [lsh_pkg::IMG_HEIGHT_BITS-1:0] value);
        return (value == 0) ? 1 : value;
    endfunction

endpackage

>>> tb/lsh_sharpen_checker.sv
// Checker for the 3x3 Laplacian sharpening block: follows the pixel stream and
// the register writes, predicts each result and compares it with the block's.
// Depends on lsh_pkg and lsh_tb_pkg.
module lsh_sharpen_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic [lsh_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [lsh_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                               pixel_valid,
    input  logic                               pixel_ready,
    input  lsh_pkg::in_item_t                  pixel_item,
    input  logic                               result_valid,
    input  logic                               result_ready,
    input  lsh_pkg::out_item_t                 result_item,
    output int                                 fail_count,
    output int                                 waiting,
    output int                                 results_checked,
    output int                                 frame_ends
);
    import lsh_pkg::*;
    import lsh_tb_pkg::*;

    localparam int PRINT_LIMIT = 100;

    rgb_t upper_row [LINE_MAX];
    rgb_t middle_row [LINE_MAX];
    rgb_t win [3][3];

    logic [IMG_WIDTH_BITS-1:0]  width_reg;
    logic [IMG_HEIGHT_BITS-1:0] height_reg;
    int unsigned in_col, in_row, out_col, out_row, slots_held;

    out_item_t sharpened_q[$];
    int errors, checked, ends_seen;

    function automatic void clear_window();
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                win[r][c] = '0;
            end
        end
    endfunction

    function automatic void restart_frame();
        clear_window();
        in_col = 0;
        in_row = 0;
        out_col = 0;
        out_row = 0;
        slots_held = 0;
    endfunction

    function automatic void shift_in(rgb_t t, rgb_t m, rgb_t b);
        for (int r = 0; r < 3; r++)
        begin
            win[r][0] = win[r][1];
            win[r][1] = win[r][2];
        end
        win[0][2] = t;
        win[1][2] = m;
        win[2][2] = b;
    endfunction

    // Eight times the centre minus the eight neighbours, clamped, per channel, and the centre plus it.
    function automatic out_item_t sharpen_window();
        out_item_t res;
        rgb_t      sharp_px;
        rgb_t      edge_px;
        int        centre;
        int        lap;
        int        sum;
        for (int ch = 0; ch < NUM_CH; ch++)
        begin
            centre = int'(win[1][1][ch]);
            lap = 8 * centre;
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    if (r != 1 || c != 1)
                    begin
                        lap -= int'(win[r][c][ch]);
                    end
                end
            end
            edge_px[ch] = (lap < 0) ? 8'd0 : ((lap > 255) ? 8'd255 : lap[7:0]);
            sum = centre + int'(edge_px[ch]);
            sharp_px[ch] = (sum > 255) ? 8'd255 : sum[7:0];
        end
        res.sharp_blue  = sharp_px[0];
        res.sharp_green = sharp_px[1];
        res.sharp_red   = sharp_px[2];
        res.edge_blue   = edge_px[0];
        res.edge_green  = edge_px[1];
        res.edge_red    = edge_px[2];
        res.frame_end   = 1'b0;
        return res;
    endfunction

    function automatic void take_slot(in_item_t it);
        int unsigned w;
        int unsigned h;
        int unsigned col;
        rgb_t        pix;
        rgb_t        t;
        rgb_t        m;
        rgb_t        b;
        out_item_t   res;
        w = line_width(width_reg);
        h = frame_rows(height_reg);
        // A drain inside the pixel part of the frame is dropped; a pixel in
        // the tail abandons the tail and opens a new frame.
        if (it.cmd == CMD_DRAIN)
        begin
            if (in_row < h)
            begin
                return;
            end
        end
        else if (in_row >= h)
        begin
            restart_frame();
        end
        col = (in_col >= LINE_MAX) ? LINE_MAX - 1 : in_col;
        pix[0] = it.pixel_blue;
        pix[1] = it.pixel_green;
        pix[2] = it.pixel_red;
        b = (in_row < h) ? pix : '0;
        m = (in_row >= 1 && in_row - 1 < h) ? middle_row[col] : '0;
        t = (in_row >= 2 && in_row - 2 < h) ? upper_row[col] : '0;
        upper_row[col] = middle_row[col];
        middle_row[col] = b;
        if (col == 0)
        begin
            // The right neighbours of a row end and the left neighbours of a row start are outside the image.
            shift_in('0, '0, '0);
            res = sharpen_window();
            clear_window();
            win[0][2] = t;
            win[1][2] = m;
            win[2][2] = b;
        end
        else
        begin
            shift_in(t, m, b);
            res = sharpen_window();
        end
        in_col++;
        if (in_col >= w)
        begin
            in_col = 0;
            in_row++;
        end
        slots_held++;
        if (slots_held <= w + 1)
        begin
            return;
        end
        slots_held--;
        if (out_row == h - 1 && out_col == w - 1)
        begin
            res.frame_end = 1'b1;
            restart_frame();
        end
        else
        begin
            out_col++;
            if (out_col >= w)
            begin
                out_col = 0;
                out_row++;
            end
        end
        sharpened_q.push_back(res);
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            if (errors < PRINT_LIMIT)
            begin
                $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            end
            errors++;
        end
    endfunction

    function automatic void compare_result(out_item_t got);
        out_item_t want;
        if (sharpened_q.size() == 0)
        begin
            if (errors < PRINT_LIMIT)
            begin
                $error("result transaction with no prediction waiting: %h", got);
            end
            errors++;
            return;
        end
        want = sharpened_q.pop_front();
        checked++;
        if (got.frame_end)
        begin
            ends_seen++;
        end
        check_field("sharp_blue", want.sharp_blue, got.sharp_blue);
        check_field("sharp_green", want.sharp_green, got.sharp_green);
        check_field("sharp_red", want.sharp_red, got.sharp_red);
        check_field("edge_blue", want.edge_blue, got.edge_blue);
        check_field("edge_green", want.edge_green, got.edge_green);
        check_field("edge_red", want.edge_red, got.edge_red);
        check_field("frame_end", want.frame_end, got.frame_end);
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            width_reg = IMG_WIDTH_BITS'(640);
            height_reg = IMG_HEIGHT_BITS'(480);
            for (int i = 0; i < LINE_MAX; i++)
            begin
                upper_row[i] = '0;
                middle_row[i] = '0;
            end
            restart_frame();
            sharpened_q.delete();
            errors = 0;
            checked = 0;
            ends_seen = 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                if (cfg_index == REG_IMAGE_WIDTH)
                begin
                    width_reg = cfg_data[IMG_WIDTH_BITS-1:0];
                end
                else
                begin
                    height_reg = cfg_data[IMG_HEIGHT_BITS-1:0];
                end
                restart_frame();
            end
            if (pixel_valid && pixel_ready)
            begin
                take_slot(pixel_item);
            end
            if (result_valid && result_ready)
            begin
                compare_result(result_item);
            end
        end
        fail_count <= errors;
        waiting <= sharpened_q.size();
        results_checked <= checked;
        frame_ends <= ends_seen;
    end

endmodule

>>> tb/testbench.sv
// Top of the sharpening testbench: clock, reset, register writes, the pixel
// stream and the result back-pressure; the checker does all the comparing.
// Depends on lsh_pkg, lsh_tb_pkg, lsh_stream_if, lsh_sharpen_checker and the block.
module testbench;
    import lsh_pkg::*;
    import lsh_tb_pkg::*;

    localparam int CLK_PERIOD = 12;
    localparam int RUN_LIMIT  = CLK_PERIOD * 600000;
    localparam int SETTLE     = 12;

    // A 3x3 frame with black, white and single-channel extremes.
    localparam logic [23:0] CORNER_PX [9] = '{
        24'h000000, 24'hFFFFFF, 24'h00FF80,
        24'hFF0000, 24'hFFFFFF, 24'h0000FF,
        24'h7F7F7F, 24'h010203, 24'hFFFFFF
    };

    typedef enum {RX_OPEN, RX_COIN, RX_HICCUP, RX_CHOKED} rx_mode_t;

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_wr_en;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;

    lsh_stream_if #(.payload_t(in_item_t))  pix_if ();
    lsh_stream_if #(.payload_t(out_item_t)) res_if ();

    int fail_count;
    int waiting;
    int results_checked;
    int frame_ends;
    int slots_sent;
    int burst_left;
    int config_writes;

    laplacian_sharpen_3x3_rgb_top #(.MAX_WIDTH(LINE_MAX)) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pixels    (pix_if),
        .results   (res_if)
    );

    lsh_sharpen_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .pixel_valid     (pix_if.valid),
        .pixel_ready     (pix_if.ready),
        .pixel_item      (pix_if.data),
        .result_valid    (res_if.valid),
        .result_ready    (res_if.ready),
        .result_item     (res_if.data),
        .fail_count      (fail_count),
        .waiting         (waiting),
        .results_checked (results_checked),
        .frame_ends      (frame_ends)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    initial
    begin
        #(RUN_LIMIT);
        $display("FAIL");
        $finish;
    end

    // Result back-pressure: stretches of free flow, coin-flip, rare hiccups
    // and heavy choking, each of random length.
    initial
    begin
        rx_mode_t mode;
        int       left;
        res_if.ready = 1'b0;
        mode = RX_OPEN;
        left = 0;
        forever
        begin
            @(posedge clk);
            if (left == 0)
            begin
                mode = rx_mode_t'($urandom_range(0, 3));
                left = $urandom_range(20, 300);
            end
            left--;
            case (mode)
                RX_OPEN:   res_if.ready <= 1'b1;
                RX_COIN:   res_if.ready <= 1'($urandom_range(0, 1));
                RX_HICCUP: res_if.ready <= ($urandom_range(0, 9) != 0);
                default:   res_if.ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    function automatic logic [7:0] channel_value();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
        begin
            return 8'd0;
        end
        if (pick == 1)
        begin
            return 8'd255;
        end
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic in_item_t random_pixel();
        in_item_t it;
        it.cmd = CMD_PIXEL;
        it.pixel_blue = channel_value();
        it.pixel_green = channel_value();
        it.pixel_red = channel_value();
        return it;
    endfunction

    function automatic in_item_t pixel_of(logic [23:0] rgb);
        in_item_t it;
        it.cmd = CMD_PIXEL;
        it.pixel_red = rgb[23:16];
        it.pixel_green = rgb[15:8];
        it.pixel_blue = rgb[7:0];
        return it;
    endfunction

    // The pixel fields of a drain carry noise; the block must ignore them.
    function automatic in_item_t drain_item();
        in_item_t it;
        it = in_item_t'($urandom);
        it.cmd = CMD_DRAIN;
        return it;
    endfunction

    task automatic send_item(in_item_t it, bit counted);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                pix_if.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 5) == 0) ? 200 : $urandom_range(1, 30);
        end
        pix_if.valid <= 1'b1;
        pix_if.data <= it;
        @(posedge clk);
        while (!pix_if.ready) @(posedge clk);
        burst_left--;
        if (counted)
        begin
            slots_sent++;
        end
    endtask

    // Hold the stream until every predicted result is out, then let the
    // block finish any slot that produces nothing.
    task automatic wait_idle();
        pix_if.valid <= 1'b0;
        burst_left = 0;
        do @(posedge clk); while (waiting != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_BITS-1:0] index, logic [CFG_DATA_BITS-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
        config_writes++;
    endtask

    task automatic configure(logic [CFG_DATA_BITS-1:0] width_val,
                             logic [CFG_DATA_BITS-1:0] height_val);
        wait_idle();
        write_reg(REG_IMAGE_WIDTH, width_val);
        write_reg(REG_IMAGE_HEIGHT, height_val);
    endtask

    // One frame of random pixels, with stray drains when noisy, and its tail; a cut
    // tail leaves the frame unfinished so that the next pixel starts over.
    task automatic send_frame(int w, int h, bit cut_tail, bit noisy);
        int drains;
        for (int i = 0; i < w * h; i++)
        begin
            if (noisy && i > 0 && $urandom_range(0, 15) == 0)
            begin
                send_item(drain_item(), 1'b0);
            end
            send_item(random_pixel(), 1'b1);
        end
        drains = cut_tail ? $urandom_range(0, w) : w + 1;
        repeat (drains) send_item(drain_item(), 1'b1);
    endtask

    initial
    begin
        int w_val;
        int h_val;
        int pick;
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        pix_if.valid = 1'b0;
        pix_if.data = '0;
        slots_sent = 0;
        burst_left = 0;
        config_writes = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // 3x3 frame with extremes and a drain among the pixels.
        configure(3, 3);
        foreach (CORNER_PX[i])
        begin
            send_item(pixel_of(CORNER_PX[i]), 1'b1);
            if (i == 3)
            begin
                send_item(drain_item(), 1'b0);
            end
        end
        repeat (4) send_item(drain_item(), 1'b1);

        // One-row frame: the first tail slot has nothing due, then a pixel
        // abandons the tail, then a complete frame.
        configure(2, 1);
        send_item(pixel_of(24'hFFFFFF), 1'b1);
        send_item(pixel_of(24'h000000), 1'b1);
        send_item(drain_item(), 1'b1);
        send_item(pixel_of(24'h00FFFF), 1'b1);
        send_item(pixel_of(24'hFF00FF), 1'b1);
        repeat (3) send_item(drain_item(), 1'b1);

        // Zero in both registers acts as a 1x1 image.
        configure(0, 0);
        send_item(pixel_of(24'hFFFFFF), 1'b1);
        repeat (2) send_item(drain_item(), 1'b1);

        while (slots_sent < 480)
        begin
            pick = $urandom_range(0, 19);
            if (pick == 0)
            begin
                w_val = 0;
                h_val = $urandom_range(0, 3);
            end
            else if (pick == 1)
            begin
                w_val = $urandom_range(1, 3);
                h_val = 0;
            end
            else if (pick < 6)
            begin
                w_val = $urandom_range(9, 40);
                h_val = $urandom_range(1, 4);
            end
            else
            begin
                w_val = $urandom_range(1, 8);
                h_val = $urandom_range(1, 6);
            end
            configure(CFG_DATA_BITS'(w_val), CFG_DATA_BITS'(h_val));
            repeat ($urandom_range(1, 3))
            begin
                send_frame(line_width(IMG_WIDTH_BITS'(w_val)),
                           frame_rows(IMG_HEIGHT_BITS'(h_val)),
                           $urandom_range(0, 7) == 0, $urandom_range(0, 4) == 0);
            end
        end

        // Widest row: the width register overflows the line store and is
        // capped; only the start of the first row is streamed.
        configure(13'h1FFF, 2);
        repeat (40) send_item(random_pixel(), 1'b1);

        // Tallest frame, left unfinished: only its first rows are streamed.
        configure(2, 13'h1FFF);
        repeat (60) send_item(random_pixel(), 1'b1);

        wait_idle();
        $display("Covered %0d pixel and drain transactions across %0d register writes,",
                 slots_sent, config_writes);
        $display("widths 1 to 40 and a capped row start, heights 1 to 8191; %0d results, %0d ends.",
                 results_checked, frame_ends);
        if (fail_count == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
